// File: design/ovlt_pkg.sv
// Package with the shared codes, types and microprogram of the ordered value list table.
package ovlt_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int MAX_RESULTS  = 16;

	typedef enum logic [2:0] {
		ACT_INS_FRONT,
		ACT_INS_BACK,
		ACT_LIST,
		ACT_SEARCH,
		ACT_REPLACE
	} action_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_FULL,
		ST_NOT_FOUND,
		ST_EMPTY
	} status_t;

	// Microprogram addresses.
	typedef enum logic [3:0] {
		PC_IDLE,
		PC_DISPATCH,
		PC_INSERT,
		PC_LIST,
		PC_LIST_RD,
		PC_LIST_EMIT,
		PC_SRCH,
		PC_SRCH_RD,
		PC_SRCH_CMP
	} pc_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_INSERT,
		OP_LIST_INIT,
		OP_LIST_EMIT,
		OP_SRCH_INIT,
		OP_SRCH_STEP
	} op_t;

	// Jump conditions: when true the sequencer goes to tgt_a, else to tgt_b.
	typedef enum logic [2:0] {
		C_ALWAYS,
		C_ACCEPT,
		C_EMPTY,
		C_LIST_END,
		C_SRCH_END,
		C_DISPATCH
	} cond_t;

	typedef struct packed {
		logic  in_ready;
		logic  emit;
		op_t   op;
		cond_t cond;
		pc_t   tgt_a;
		pc_t   tgt_b;
	} ucode_t;

	function automatic ucode_t ucode_rom(input pc_t pc);
		ucode_t uw;
		unique case (pc)
			PC_IDLE:      uw = '{1'b1, 1'b0, OP_NOP,       C_ACCEPT,   PC_DISPATCH,  PC_IDLE};
			PC_DISPATCH:  uw = '{1'b0, 1'b0, OP_NOP,       C_DISPATCH, PC_IDLE,      PC_IDLE};
			PC_INSERT:    uw = '{1'b0, 1'b1, OP_INSERT,    C_ALWAYS,   PC_IDLE,      PC_IDLE};
			PC_LIST:      uw = '{1'b0, 1'b1, OP_LIST_INIT, C_EMPTY,    PC_IDLE,      PC_LIST_RD};
			PC_LIST_RD:   uw = '{1'b0, 1'b0, OP_NOP,       C_ALWAYS,   PC_LIST_EMIT, PC_LIST_EMIT};
			PC_LIST_EMIT: uw = '{1'b0, 1'b1, OP_LIST_EMIT, C_LIST_END, PC_IDLE,      PC_LIST_RD};
			PC_SRCH:      uw = '{1'b0, 1'b1, OP_SRCH_INIT, C_EMPTY,    PC_IDLE,      PC_SRCH_RD};
			PC_SRCH_RD:   uw = '{1'b0, 1'b0, OP_NOP,       C_ALWAYS,   PC_SRCH_CMP,  PC_SRCH_CMP};
			PC_SRCH_CMP:  uw = '{1'b0, 1'b1, OP_SRCH_STEP, C_SRCH_END, PC_IDLE,      PC_SRCH_RD};
			default:      uw = '{1'b0, 1'b0, OP_NOP,       C_ALWAYS,   PC_IDLE,      PC_IDLE};
		endcase
		return uw;
	endfunction

endpackage

// File: design/ordered_value_list_table.sv
// Top level of the ordered value list table: microcoded sequencer, list store and output register.
//
// The block keeps an ordered list of up to CAPACITY signed 32-bit values in a circular store
// and takes one command item at a time on the s_ side: insert at the front, insert at the back,
// list all entries, search for a key, or replace the first entry equal to a key. Every command
// gives one result item on the m_ side, except a listing of a non-empty list, which gives one
// result per entry (front first, at most 16) with m_tlast on the final one. An insert into a
// full list, a search or replace that finds nothing, and a listing of an empty list each give a
// single result whose status tells the case, with zero position and value. Unused action codes
// are dropped with no result. A listing or a search works through the entries front first, and
// for each entry it takes a read step and then an emit or compare step, since the list store
// has a single read port whose read data is registered before it is compared or sent. A
// finished result sits in the output register, so the next command can be accepted while the
// last result still waits for m_tready; a result that cannot be loaded because the register
// is still full stalls the sequencer. The store needs no clearing after reset: only entries
// inside the list are ever read.
module ordered_value_list_table
	import ovlt_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] value, [63:32] new_value
	input  logic [2:0]  s_tuser,   // [2:0] action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [3:0] position, [35:4] entry_value, [39:36] zero
	output logic [1:0]  m_tuser,   // [1:0] status
	output logic        m_tlast
);

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int SW = IW + 1;

	// Sequencer state and the current control word.
	pc_t    pc_q, pc_d;
	ucode_t uw;
	logic   step_go;
	logic   s_accept;

	// Command held while it is worked on.
	logic [2:0]  action_q;
	logic [31:0] key_q;
	logic [31:0] nval_q;

	// List bookkeeping.
	logic [IW-1:0] front_q, front_d;
	logic [CW-1:0] count_q, count_d;
	logic [IW-1:0] idx_q, idx_d;
	logic [IW-1:0] slot_q, slot_d;

	// List store with one write port and one registered read port.
	logic [31:0]   mem_q [CAPACITY];
	logic [31:0]   rdata_q;
	logic          we;
	logic [IW-1:0] waddr;
	logic [31:0]   wdata;

	// Output register.
	logic        out_valid_q;
	status_t     out_status_q;
	logic [3:0]  out_pos_q;
	logic [31:0] out_val_q;
	logic        out_last_q;
	logic        load_out;
	status_t     o_status;
	logic [3:0]  o_pos;
	logic [31:0] o_val;

	// Derived conditions.
	logic          empty, full, match, at_back, list_end, srch_end;
	logic [IW-1:0] front_dec, slot_inc, back_slot;
	logic [SW-1:0] back_sum;

	assign uw       = ucode_rom(pc_q);
	assign s_tready = uw.in_ready;
	assign s_accept = s_tvalid && uw.in_ready;

	// A step that may emit waits until the output register is free.
	assign step_go = !(uw.emit && out_valid_q && !m_tready);

	assign empty    = (count_q == '0);
	assign full     = (count_q == CW'(CAPACITY));
	assign match    = (rdata_q == key_q);
	assign at_back  = ((CW'(idx_q) + CW'(1)) == count_q);
	assign list_end = at_back || (32'(idx_q) == MAX_RESULTS - 1);
	assign srch_end = match || at_back;

	assign front_dec = (front_q == '0) ? IW'(CAPACITY - 1) : front_q - IW'(1);
	assign slot_inc  = (slot_q == IW'(CAPACITY - 1)) ? '0 : slot_q + IW'(1);
	assign back_sum  = SW'(front_q) + SW'(count_q);
	assign back_slot = (back_sum >= SW'(CAPACITY)) ? IW'(back_sum - SW'(CAPACITY))
	                                               : IW'(back_sum);

	// Next step of the microprogram.
	always_comb begin
		pc_d = pc_q;
		if (step_go) begin
			unique case (uw.cond)
				C_ALWAYS:   pc_d = uw.tgt_a;
				C_ACCEPT:   pc_d = s_accept ? uw.tgt_a : uw.tgt_b;
				C_EMPTY:    pc_d = empty ? uw.tgt_a : uw.tgt_b;
				C_LIST_END: pc_d = list_end ? uw.tgt_a : uw.tgt_b;
				C_SRCH_END: pc_d = srch_end ? uw.tgt_a : uw.tgt_b;
				C_DISPATCH: begin
					unique case (action_q)
						ACT_INS_FRONT, ACT_INS_BACK: pc_d = PC_INSERT;
						ACT_LIST:                    pc_d = PC_LIST;
						ACT_SEARCH, ACT_REPLACE:     pc_d = PC_SRCH;
						default:                     pc_d = PC_IDLE;
					endcase
				end
				default:    pc_d = PC_IDLE;
			endcase
		end
	end

	// Datapath controls decoded from the operation field.
	always_comb begin
		front_d  = front_q;
		count_d  = count_q;
		idx_d    = idx_q;
		slot_d   = slot_q;
		we       = 1'b0;
		waddr    = slot_q;
		wdata    = key_q;
		load_out = 1'b0;
		o_status = ST_OK;
		o_pos    = '0;
		o_val    = '0;
		if (step_go) begin
			unique case (uw.op)
				OP_NOP: begin
				end
				OP_INSERT: begin
					load_out = 1'b1;
					if (full) begin
						o_status = ST_FULL;
					end else begin
						we      = 1'b1;
						count_d = count_q + CW'(1);
						o_val   = key_q;
						if (action_q == ACT_INS_FRONT) begin
							waddr   = front_dec;
							front_d = front_dec;
						end else begin
							waddr = back_slot;
							o_pos = 4'(count_q);
						end
					end
				end
				OP_LIST_INIT, OP_SRCH_INIT: begin
					idx_d  = '0;
					slot_d = front_q;
					if (empty) begin
						load_out = 1'b1;
						o_status = (uw.op == OP_LIST_INIT) ? ST_EMPTY : ST_NOT_FOUND;
					end
				end
				OP_LIST_EMIT: begin
					load_out = 1'b1;
					o_pos    = 4'(idx_q);
					o_val    = rdata_q;
					idx_d    = idx_q + IW'(1);
					slot_d   = slot_inc;
				end
				OP_SRCH_STEP: begin
					if (match) begin
						load_out = 1'b1;
						o_pos    = 4'(idx_q);
						if (action_q == ACT_REPLACE) begin
							we    = 1'b1;
							wdata = nval_q;
							o_val = nval_q;
						end else begin
							o_val = rdata_q;
						end
					end else if (at_back) begin
						load_out = 1'b1;
						o_status = ST_NOT_FOUND;
					end else begin
						idx_d  = idx_q + IW'(1);
						slot_d = slot_inc;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= PC_IDLE;
			front_q     <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			pc_q    <= pc_d;
			front_q <= front_d;
			count_q <= count_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		idx_q  <= idx_d;
		slot_q <= slot_d;
		if (s_accept) begin
			action_q <= s_tuser;
			key_q    <= s_tdata[31:0];
			nval_q   <= s_tdata[63:32];
		end
		if (load_out) begin
			out_status_q <= o_status;
			out_pos_q    <= o_pos;
			out_val_q    <= o_val;
			out_last_q   <= (uw.op == OP_LIST_EMIT) ? list_end : 1'b1;
		end
	end

	// List store.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[slot_q];
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, out_val_q, out_pos_q};
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;

endmodule

// File: design/ovlt_checker.sv
// Port checker for the ordered value list table and its bind to the top level.
module ovlt_checker
	import ovlt_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);

	// A stalled result holds still.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled result changed");

	// Any status other than ok is a single result with zero position and value.
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != ST_OK) |-> m_tlast && (m_tdata == '0))
		else $error("error result malformed");

	// While a listing is still in progress no new command is taken.
	a_list_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("command taken during listing");

	// After a command is accepted the block is busy in the next cycle.
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("ready stayed high after accept");

endmodule

bind ordered_value_list_table ovlt_checker u_ovlt_checker (.*);
